/* src/assert_macros.svh */
// Assertion helpers shared by the parser modules.
// Each macro expects clk_i and rst_ni in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/todtp_pkg.sv */
// ----------------------------------------------------------------------------
// todtp_pkg
// Shared types, character codes and constants of the time-of-day parser.
// ----------------------------------------------------------------------------
package todtp_pkg;

  // Result field widths
  localparam int TOTAL_W = 44;
  localparam int MICRO_W = 20;

  // Parameter defaults
  localparam int FRACTION_DIGITS_DEF = 6;
  localparam int NUMBER_BITS_DEF     = 31;

  // Time constants
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam logic [MICRO_W-1:0] MICROS_PER_SEC = 20'd1000000;
  localparam logic [3:0] ROUND_DIGIT = 4'd5;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;

  // Parser phase
  typedef enum logic [2:0] {
    PH_FIRST        = 3'd0,
    PH_FIRST_SIGNED = 3'd1,
    PH_MIN          = 3'd2,
    PH_SEC          = 3'd3,
    PH_FRAC         = 3'd4,
    PH_SKIP         = 3'd5
  } phase_e;

  // Control of one finished-string record
  typedef struct packed {
    logic valid;
    logic ok;
  } rec_ctrl_t;

  // Microsecond weight of fraction digit k (first digit after the dot is 0)
  function automatic logic [MICRO_W-1:0] weight_at(logic [2:0] k);
    logic [MICRO_W-1:0] w;
    unique case (k)
      3'd0:    w = 20'd100000;
      3'd1:    w = 20'd10000;
      3'd2:    w = 20'd1000;
      3'd3:    w = 20'd100;
      3'd4:    w = 20'd10;
      3'd5:    w = 20'd1;
      default: w = 20'd0;
    endcase
    return w;
  endfunction

endpackage

/* src/todtp_parse.sv */
// ----------------------------------------------------------------------------
// todtp_parse
// Input register and character-level parse state; emits one record of
// time components per string on its last character.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module todtp_parse #(
  parameter int FRACTION_DIGITS = todtp_pkg::FRACTION_DIGITS_DEF,
  parameter int NUMBER_BITS     = todtp_pkg::NUMBER_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         character_i,
  input  logic                               is_last_i,
  output todtp_pkg::rec_ctrl_t               rec_o,
  input  logic                               rec_stall_i,
  output logic signed [NUMBER_BITS:0]        rec_hours_o,
  output logic [NUMBER_BITS-1:0]             rec_minutes_o,
  output logic signed [NUMBER_BITS+1:0]      rec_seconds_o,
  output logic [todtp_pkg::MICRO_W-1:0]      rec_micros_o
);

  localparam int NB = NUMBER_BITS;
  localparam int PW = $clog2(FRACTION_DIGITS + 1);

  typedef struct packed {
    todtp_pkg::phase_e               phase;
    logic [NB-1:0]                   accum;
    logic                            negative;
    logic                            digits;
    logic signed [NB:0]              hours;
    logic [NB-1:0]                   minutes;
    logic signed [NB+1:0]            secs;
    logic [todtp_pkg::MICRO_W-1:0]   frac;
    logic [PW-1:0]                   fpos;
    logic                            stopped;
    logic                            failed;
  } parse_t;

  // One parser step; at_end feeds the end-of-string marker instead of ch
  function automatic parse_t feed(parse_t s, logic [7:0] ch, logic at_end);
    parse_t r;
    logic is_digit;
    logic is_space;
    logic is_colon;
    logic is_dot;
    logic is_sign;
    logic [3:0] d;
    logic [NB+3:0] nxt;
    logic signed [NB:0] v;
    logic [todtp_pkg::MICRO_W-1:0] fr;
    r        = s;
    is_digit = !at_end && (ch >= todtp_pkg::CH_ZERO) && (ch <= todtp_pkg::CH_NINE);
    is_space = !at_end && ((ch == todtp_pkg::CH_SPACE) ||
               ((ch >= todtp_pkg::CH_TAB) && (ch <= todtp_pkg::CH_CR)));
    is_colon = !at_end && (ch == todtp_pkg::CH_COLON);
    is_dot   = !at_end && (ch == todtp_pkg::CH_DOT);
    is_sign  = !at_end && ((ch == todtp_pkg::CH_PLUS) || (ch == todtp_pkg::CH_MINUS));
    d        = is_digit ? ch[3:0] : 4'd0;
    nxt      = (NB+4)'({s.accum, 3'b000}) + (NB+4)'({s.accum, 1'b0}) + (NB+4)'(d);
    v        = s.negative ? -$signed({1'b0, s.accum}) : $signed({1'b0, s.accum});
    fr       = s.frac;
    unique case (s.phase)
      todtp_pkg::PH_FIRST, todtp_pkg::PH_FIRST_SIGNED,
      todtp_pkg::PH_MIN, todtp_pkg::PH_SEC: begin
        if (is_digit) begin
          // accumulate, fail on magnitude overflow
          if (nxt[NB+3:NB] != '0) begin
            r.failed  = 1'b1;
            r.stopped = 1'b1;
          end else begin
            r.accum  = nxt[NB-1:0];
            r.digits = 1'b1;
          end
        end else if (!s.digits) begin
          if (s.phase != todtp_pkg::PH_FIRST_SIGNED && is_space) begin
            r.stopped = s.stopped;
          end else if (s.phase == todtp_pkg::PH_FIRST && is_sign) begin
            r.negative = (ch == todtp_pkg::CH_MINUS);
            r.phase    = todtp_pkg::PH_FIRST_SIGNED;
          end else begin
            r.failed  = 1'b1;
            r.stopped = 1'b1;
          end
        end else begin
          // number ended by this character
          r.accum    = '0;
          r.digits   = 1'b0;
          r.negative = 1'b0;
          if (s.phase == todtp_pkg::PH_FIRST || s.phase == todtp_pkg::PH_FIRST_SIGNED) begin
            if (is_colon) begin
              r.hours = v;
              r.phase = todtp_pkg::PH_MIN;
            end else begin
              r.secs    = (NB+2)'(v);
              r.hours   = '0;
              r.minutes = '0;
              if (is_dot) r.phase = todtp_pkg::PH_FRAC;
              else        r.stopped = 1'b1;
            end
          end else if (s.phase == todtp_pkg::PH_MIN) begin
            r.minutes = s.accum;
            if (is_colon) begin
              r.phase = todtp_pkg::PH_SEC;
            end else begin
              r.secs    = '0;
              r.stopped = 1'b1;
            end
          end else begin
            r.secs = (NB+2)'(v);
            if (is_dot) r.phase = todtp_pkg::PH_FRAC;
            else        r.stopped = 1'b1;
          end
        end
      end
      todtp_pkg::PH_FRAC: begin
        if (!is_digit) begin
          r.stopped = 1'b1;
        end else if (s.fpos < PW'(FRACTION_DIGITS)) begin
          r.frac = s.frac + 20'(d) * todtp_pkg::weight_at(3'(s.fpos));
          r.fpos = s.fpos + PW'(1);
        end else begin
          // rounding digit, carry into seconds on overflow
          if (d >= todtp_pkg::ROUND_DIGIT) begin
            fr = s.frac + todtp_pkg::weight_at(3'(FRACTION_DIGITS - 1));
            if (fr >= todtp_pkg::MICROS_PER_SEC) begin
              r.frac = '0;
              r.secs = s.secs + (NB+2)'(1);
            end else begin
              r.frac = fr;
            end
          end
          r.phase = todtp_pkg::PH_SKIP;
        end
      end
      todtp_pkg::PH_SKIP: begin
        if (!is_digit) r.stopped = 1'b1;
      end
      default: begin
        r.failed  = 1'b1;
        r.stopped = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] char_q;
  logic       last_q;
  logic       in_acc;
  logic       adv;

  // Parse state and record register
  parse_t st_q, st_d;
  parse_t s_char, s_end;
  logic   rec_rdy;
  logic   rec_vld_q, rec_vld_d;
  logic   rec_ok_q;
  logic signed [NB:0]            rec_hours_q;
  logic [NB-1:0]                 rec_minutes_q;
  logic signed [NB+1:0]          rec_seconds_q;
  logic [todtp_pkg::MICRO_W-1:0] rec_micros_q;

  // Handshake and advance
  assign rec_rdy    = !rec_vld_q || !rec_stall_i;
  assign adv        = in_vld_q && (!last_q || rec_rdy);
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc)   in_vld_d = 1'b1;
    else if (adv) in_vld_d = 1'b0;
  end

  // Parse step, plus end-of-string step on the last character
  always_comb begin
    s_char = st_q.stopped ? st_q : feed(st_q, char_q, 1'b0);
    s_end  = s_char.stopped ? s_char : feed(s_char, char_q, 1'b1);
    st_d   = st_q;
    if (adv) begin
      if (last_q) st_d = '0;
      else        st_d = s_char;
    end
  end

  assign rec_vld_d = rec_rdy ? (adv && last_q) : rec_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      st_q      <= '0;
      rec_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      st_q      <= st_d;
      rec_vld_q <= rec_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      char_q <= character_i;
      last_q <= is_last_i;
    end
    if (adv && last_q) begin
      rec_ok_q      <= !s_end.failed;
      rec_hours_q   <= s_end.hours;
      rec_minutes_q <= s_end.minutes;
      rec_seconds_q <= s_end.secs;
      rec_micros_q  <= s_end.frac;
    end
  end

  assign rec_o.valid   = rec_vld_q;
  assign rec_o.ok      = rec_ok_q;
  assign rec_hours_o   = rec_hours_q;
  assign rec_minutes_o = rec_minutes_q;
  assign rec_seconds_o = rec_seconds_q;
  assign rec_micros_o  = rec_micros_q;

  // Assertions
  `ASSERT_NXT(a_rec_loaded, adv && last_q, rec_vld_q)
  `ASSERT_IMP(a_stall_only_on_full_rec, in_stall_o, in_vld_q && last_q && rec_vld_q)
  `ASSERT_NXT(a_rec_held, rec_vld_q && rec_stall_i, rec_vld_q && $stable(rec_seconds_q))

endmodule

/* src/todtp_sum.sv */
// ----------------------------------------------------------------------------
// todtp_sum
// Folds hours, minutes and seconds into total seconds over two stages and
// keeps the held time in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module todtp_sum #(
  parameter int NUMBER_BITS = todtp_pkg::NUMBER_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  todtp_pkg::rec_ctrl_t                 rec_i,
  output logic                                 rec_stall_o,
  input  logic signed [NUMBER_BITS:0]          rec_hours_i,
  input  logic [NUMBER_BITS-1:0]               rec_minutes_i,
  input  logic signed [NUMBER_BITS+1:0]        rec_seconds_i,
  input  logic [todtp_pkg::MICRO_W-1:0]        rec_micros_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [todtp_pkg::TOTAL_W-1:0] total_seconds_o,
  output logic [todtp_pkg::MICRO_W-1:0]        microseconds_o,
  output logic                                 ok_o
);

  localparam int TW = todtp_pkg::TOTAL_W;

  logic b_rdy, out_rdy;
  logic b_vld_q, b_vld_d;
  logic b_ok_q;
  logic [TW-1:0] b_ph_q, b_pms_q;
  logic [todtp_pkg::MICRO_W-1:0] b_micros_q;
  logic signed [TW-1:0] h_ext;
  logic [TW-1:0] ph_d, pms_d;

  logic out_vld_q, out_vld_d;
  logic ok_q;
  logic [TW-1:0] total_q, total_d;
  logic [todtp_pkg::MICRO_W-1:0] micros_q, micros_d;

  // Stage handshake
  assign out_rdy     = !out_vld_q || !out_stall_i;
  assign b_rdy       = !b_vld_q || out_rdy;
  assign rec_stall_o = !b_rdy;
  assign b_vld_d     = b_rdy ? rec_i.valid : b_vld_q;
  assign out_vld_d   = out_rdy ? b_vld_q : out_vld_q;

  // Partial products
  assign h_ext = TW'(rec_hours_i);
  assign ph_d  = h_ext * TW'(todtp_pkg::SEC_PER_HOUR);
  assign pms_d = TW'(rec_minutes_i) * TW'(todtp_pkg::SEC_PER_MIN) + TW'(rec_seconds_i);

  // Held time is replaced only by a successful parse
  always_comb begin
    total_d  = total_q;
    micros_d = micros_q;
    if (out_rdy && b_vld_q && b_ok_q) begin
      total_d  = b_ph_q + b_pms_q;
      micros_d = b_micros_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
      total_q   <= '0;
      micros_q  <= '0;
    end else begin
      b_vld_q   <= b_vld_d;
      out_vld_q <= out_vld_d;
      total_q   <= total_d;
      micros_q  <= micros_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (b_rdy && rec_i.valid) begin
      b_ok_q     <= rec_i.ok;
      b_ph_q     <= ph_d;
      b_pms_q    <= pms_d;
      b_micros_q <= rec_micros_i;
    end
    if (out_rdy && b_vld_q) begin
      ok_q <= b_ok_q;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign total_seconds_o = $signed(total_q);
  assign microseconds_o  = micros_q;
  assign ok_o            = ok_q;

  // Assertions
  `ASSERT_NXT(a_fail_keeps_time, out_rdy && b_vld_q && !b_ok_q, $stable(total_q) && $stable(micros_q))
  `ASSERT_IMP(a_micros_range, out_vld_q, micros_q < todtp_pkg::MICROS_PER_SEC)
  `ASSERT_IMP(a_rec_stall_cause, rec_stall_o, b_vld_q && out_vld_q && out_stall_i)

endmodule

/* src/time_of_day_text_parser_top.sv */
// Result path: the result of a string passes the record, fold and output
// registers after its last character is accepted; other characters give no result.
// Throughput: one character per cycle while in_stall_o is low, set by the
// single-step parse register. Reset (rst_ni, asynchronous, active low) clears
// the parse state and the held time to zero.
// ----------------------------------------------------------------------------
// time_of_day_text_parser_top
// Parses H:M, H:M:S[.frac] and S[.frac] strings one character per
// transaction and returns total seconds, microseconds and a success flag.
// ----------------------------------------------------------------------------
module time_of_day_text_parser_top #(
  parameter int FRACTION_DIGITS = todtp_pkg::FRACTION_DIGITS_DEF,
  parameter int NUMBER_BITS     = todtp_pkg::NUMBER_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           character_i,
  input  logic                                 is_last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [todtp_pkg::TOTAL_W-1:0] total_seconds_o,
  output logic [todtp_pkg::MICRO_W-1:0]        microseconds_o,
  output logic                                 ok_o
);

  todtp_pkg::rec_ctrl_t                rec;
  logic                                rec_stall;
  logic signed [NUMBER_BITS:0]         rec_hours;
  logic [NUMBER_BITS-1:0]              rec_minutes;
  logic signed [NUMBER_BITS+1:0]       rec_seconds;
  logic [todtp_pkg::MICRO_W-1:0]       rec_micros;

  // Character parser
  todtp_parse #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .NUMBER_BITS     (NUMBER_BITS)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .character_i   (character_i),
    .is_last_i     (is_last_i),
    .rec_o         (rec),
    .rec_stall_i   (rec_stall),
    .rec_hours_o   (rec_hours),
    .rec_minutes_o (rec_minutes),
    .rec_seconds_o (rec_seconds),
    .rec_micros_o  (rec_micros)
  );

  // Total-seconds fold and held time
  todtp_sum #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_sum (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rec_i           (rec),
    .rec_stall_o     (rec_stall),
    .rec_hours_i     (rec_hours),
    .rec_minutes_i   (rec_minutes),
    .rec_seconds_i   (rec_seconds),
    .rec_micros_i    (rec_micros),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .total_seconds_o (total_seconds_o),
    .microseconds_o  (microseconds_o),
    .ok_o            (ok_o)
  );

endmodule

/* tb/time_of_day_text_parser_checker.sv */
// ----------------------------------------------------------------------------
// Time-of-day parser checker
// Watches the character and result channels of the parser. Each accepted
// character is run through a local parse model; a character flagged last
// queues the expected time. Each accepted result is compared field by field
// with the oldest queued time.
// ----------------------------------------------------------------------------
module tod_parse_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic [7:0]                           character_i,
  input  logic                                 is_last_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [todtp_pkg::TOTAL_W-1:0] total_seconds_i,
  input  logic [todtp_pkg::MICRO_W-1:0]        microseconds_i,
  input  logic                                 ok_i,
  output int                                   fail_count_o,
  output int                                   pending_o,
  output int                                   checked_o,
  output int                                   parsed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint MAG_LIMIT = (longint'(1) << todtp_pkg::NUMBER_BITS_DEF) - 1;
  localparam int END_OF_TEXT = -1;
  localparam int FDIGITS     = todtp_pkg::FRACTION_DIGITS_DEF;

  typedef struct packed {
    logic [todtp_pkg::TOTAL_W-1:0] secs;
    logic [todtp_pkg::MICRO_W-1:0] usecs;
    logic                          ok;
  } tod_result_t;

  // Parse model state
  todtp_pkg::phase_e parse_phase;
  longint            mag_acc;
  bit                neg_sign;
  bit                have_digits;
  longint            hh, mm, ss;
  int unsigned       frac_us;
  int                frac_pos;
  bit                done;
  bit                bad;
  longint            held_total;
  int unsigned       held_us;

  tod_result_t expected_times[$];
  tod_result_t fresh, oldest;
  int n_fail    = 0;
  int n_checked = 0;
  int n_parsed  = 0;

  // Microsecond value of one digit at fraction position pos
  function automatic int unsigned place_weight(input int pos);
    int unsigned w;
    w = 1;
    for (int i = pos + 1; i < FDIGITS; i++) w = w * 10;
    return w;
  endfunction

  task automatic restart_parse();
    parse_phase = todtp_pkg::PH_FIRST;
    mag_acc     = 0;
    neg_sign    = 1'b0;
    have_digits = 1'b0;
    hh          = 0;
    mm          = 0;
    ss          = 0;
    frac_us     = 0;
    frac_pos    = 0;
    done        = 1'b0;
    bad         = 1'b0;
  endtask

  // Stop the parse; a good finish replaces the held time
  task automatic finish_parse(input bit good);
    if (good) begin
      held_total = hh * todtp_pkg::SEC_PER_HOUR + mm * todtp_pkg::SEC_PER_MIN + ss;
      held_us    = frac_us;
    end else begin
      bad = 1'b1;
    end
    done = 1'b1;
  endtask

  // A non-digit closes the number being read; c decides what comes next
  task automatic close_number(input int c);
    longint v;
    v = neg_sign ? -mag_acc : mag_acc;
    mag_acc     = 0;
    have_digits = 1'b0;
    neg_sign    = 1'b0;
    case (parse_phase)
      todtp_pkg::PH_FIRST, todtp_pkg::PH_FIRST_SIGNED: begin
        if (c == int'(todtp_pkg::CH_COLON)) begin
          hh          = v;
          parse_phase = todtp_pkg::PH_MIN;
        end else begin
          ss = v;
          hh = 0;
          mm = 0;
          if (c == int'(todtp_pkg::CH_DOT)) parse_phase = todtp_pkg::PH_FRAC;
          else finish_parse(1'b1);
        end
      end
      todtp_pkg::PH_MIN: begin
        mm = v;
        if (c == int'(todtp_pkg::CH_COLON)) begin
          parse_phase = todtp_pkg::PH_SEC;
        end else begin
          // H:M ends here, a dot included
          ss = 0;
          finish_parse(1'b1);
        end
      end
      default: begin
        ss = v;
        if (c == int'(todtp_pkg::CH_DOT)) parse_phase = todtp_pkg::PH_FRAC;
        else finish_parse(1'b1);
      end
    endcase
  endtask

  // One character of the string, or END_OF_TEXT after the last one
  task automatic parse_char(input int c);
    bit          is_dig;
    bit          is_ws;
    int unsigned dig;
    longint      grown;
    is_dig = (c >= int'(todtp_pkg::CH_ZERO)) && (c <= int'(todtp_pkg::CH_NINE));
    is_ws  = (c == int'(todtp_pkg::CH_SPACE)) ||
             (c >= int'(todtp_pkg::CH_TAB) && c <= int'(todtp_pkg::CH_CR));
    dig    = is_dig ? c - int'(todtp_pkg::CH_ZERO) : 0;
    case (parse_phase)
      todtp_pkg::PH_FIRST, todtp_pkg::PH_FIRST_SIGNED,
      todtp_pkg::PH_MIN, todtp_pkg::PH_SEC: begin
        if (is_dig) begin
          grown = mag_acc * 10 + dig;
          if (grown > MAG_LIMIT) begin
            finish_parse(1'b0);
          end else begin
            mag_acc     = grown;
            have_digits = 1'b1;
          end
        end else if (!have_digits) begin
          if (is_ws && parse_phase != todtp_pkg::PH_FIRST_SIGNED) begin
            // leading blank, keep waiting for the number
          end else if (parse_phase == todtp_pkg::PH_FIRST &&
                       (c == int'(todtp_pkg::CH_PLUS) ||
                        c == int'(todtp_pkg::CH_MINUS))) begin
            neg_sign    = (c == int'(todtp_pkg::CH_MINUS));
            parse_phase = todtp_pkg::PH_FIRST_SIGNED;
          end else begin
            finish_parse(1'b0);
          end
        end else begin
          close_number(c);
        end
      end
      todtp_pkg::PH_FRAC: begin
        if (!is_dig) begin
          finish_parse(1'b1);
        end else if (frac_pos < FDIGITS) begin
          frac_us  = frac_us + dig * place_weight(frac_pos);
          frac_pos = frac_pos + 1;
        end else begin
          // digit past the last place rounds, carrying into the seconds
          if (dig >= todtp_pkg::ROUND_DIGIT) begin
            frac_us = frac_us + place_weight(FDIGITS - 1);
            if (frac_us >= todtp_pkg::MICROS_PER_SEC) begin
              frac_us = 0;
              ss      = ss + 1;
            end
          end
          parse_phase = todtp_pkg::PH_SKIP;
        end
      end
      todtp_pkg::PH_SKIP: begin
        if (!is_dig) finish_parse(1'b1);
      end
      default: finish_parse(1'b0);
    endcase
  endtask

  // Compare results, then run accepted characters through the model
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      held_total = 0;
      held_us    = 0;
      expected_times.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_times.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] result with nothing expected: %0d s %0d us ok=%0b",
                     $time, total_seconds_i, microseconds_i, ok_i);
        end else begin
          oldest = expected_times.pop_front();
          n_checked++;
          if (oldest.ok) n_parsed++;
          if (total_seconds_i !== oldest.secs || microseconds_i !== oldest.usecs ||
              ok_i !== oldest.ok) begin
            n_fail++;
            if (n_fail <= 10)
              $display({"[%0t] time mismatch: expected %0d s %0d us ok=%0b, ",
                        "got %0d s %0d us ok=%0b"},
                       $time, $signed(oldest.secs), oldest.usecs, oldest.ok,
                       total_seconds_i, microseconds_i, ok_i);
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        if (!done) parse_char(int'(character_i));
        if (is_last_i) begin
          if (!done) parse_char(END_OF_TEXT);
          fresh.secs  = held_total[todtp_pkg::TOTAL_W-1:0];
          fresh.usecs = held_us[todtp_pkg::MICRO_W-1:0];
          fresh.ok    = !bad;
          expected_times.push_back(fresh);
          restart_parse();
        end
      end
    end
    fail_count_o <= n_fail;
    pending_o    <= expected_times.size();
    checked_o    <= n_checked;
    parsed_o     <= n_parsed;
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Time-of-day parser testbench
// Sends directed time strings covering every form and corner of the parser,
// then random well-formed, broken and noise strings in bursts with gaps while
// the result side stalls in changing patterns. The checker predicts each
// result; this module drives the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_CHARS = 1150;
  localparam int CYCLE_LIMIT  = 400000;

  logic                                 clk_i       = 1'b0;
  logic                                 rst_ni      = 1'b0;
  logic                                 in_valid_i  = 1'b0;
  logic                                 in_stall_o;
  logic [7:0]                           character_i = 8'h00;
  logic                                 is_last_i   = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [todtp_pkg::TOTAL_W-1:0] total_seconds_o;
  logic [todtp_pkg::MICRO_W-1:0]        microseconds_o;
  logic                                 ok_o;

  int fail_count, pending, checked, parsed;
  int chars_sent   = 0;
  int strings_sent = 0;
  int burst_left   = 0;
  int cycle_count  = 0;
  logic [7:0] text_q[$];

  always #6 clk_i = ~clk_i;

  time_of_day_text_parser_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .character_i    (character_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .total_seconds_o(total_seconds_o),
    .microseconds_o (microseconds_o),
    .ok_o           (ok_o)
  );

  tod_parse_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .character_i    (character_i),
    .is_last_i      (is_last_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .total_seconds_i(total_seconds_o),
    .microseconds_i (microseconds_o),
    .ok_i           (ok_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .checked_o      (checked),
    .parsed_o       (parsed)
  );

  // Result-side stall: free, random, periodic and heavy stretches in turn;
  // the cycle counter also bounds the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[8:7])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 2) == 0);
      2'd2:    out_stall_i <= (cycle_count[2:0] < 3'd3);
      default: out_stall_i <= ($urandom_range(0, 5) != 0);
    endcase
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  // One character transaction; bursts end in a random gap, sometimes none
  task automatic send_byte(input logic [7:0] ch, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i  <= 1'b0;
        character_i <= 8'($urandom);
        is_last_i   <= 1'($urandom);
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 32);
    end
    in_valid_i  <= 1'b1;
    character_i <= ch;
    is_last_i   <= last;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    strings_sent++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic run_text(input string s);
    text_q.delete();
    push_text(s);
    send_text();
  endtask

  // Hold off the sender until every queued result has been checked
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Optional blanks, optional sign, then a number of mostly few digits
  task automatic push_number(input bit with_sign);
    int pick, ndig, sel;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        sel = $urandom_range(0, 5);
        text_q.push_back(sel == 5 ? todtp_pkg::CH_SPACE : 8'(todtp_pkg::CH_TAB + sel));
      end
    end
    if (with_sign && $urandom_range(0, 3) == 0)
      text_q.push_back($urandom_range(0, 1) ? todtp_pkg::CH_MINUS : todtp_pkg::CH_PLUS);
    pick = $urandom_range(0, 31);
    if (pick == 0) begin
      push_text("2147483647");
    end else if (pick == 1) begin
      push_text("2147483648");
    end else begin
      ndig = (pick < 26) ? $urandom_range(1, 2) : $urandom_range(3, 11);
      repeat (ndig) text_q.push_back(8'(todtp_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // Dot and up to nine digits; runs of nines drive the rounding carry
  task automatic push_fraction();
    bit nines;
    if ($urandom_range(0, 2) != 0) begin
      nines = ($urandom_range(0, 3) == 0);
      text_q.push_back(todtp_pkg::CH_DOT);
      repeat ($urandom_range(0, 9))
        text_q.push_back(8'(todtp_pkg::CH_ZERO + (nines ? 9 : $urandom_range(0, 9))));
    end
  endtask

  // Random string: mostly well-formed forms, some mutated, some pure noise
  task automatic build_random_text();
    int kind;
    text_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 8) begin
      repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
    end else begin
      push_number(1'b1);
      if (kind != 5 && kind != 6) begin
        text_q.push_back(todtp_pkg::CH_COLON);
        push_number($urandom_range(0, 15) == 0);
      end
      if ((kind >= 2 && kind <= 4) || kind == 9) begin
        text_q.push_back(todtp_pkg::CH_COLON);
        push_number($urandom_range(0, 15) == 0);
      end
      if (kind >= 2) push_fraction();
      if (kind == 9) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed forms and corners
    run_text("12:34");
    run_text(" \t+1:02:03.5");
    run_text("-1:2:3.123456");
    run_text("0:0:59.9999995");
    run_text("7.4999994");
    run_text("3.1234567890");
    run_text("2147483647:2147483647:2147483647.9999999");
    run_text("2147483648");
    run_text("-2147483647");
    run_text(" ");
    run_text("-");
    run_text("+ 5");
    run_text("1:-2");
    run_text("1:2.75");
    run_text("5 :3");
    run_text("7.");
    run_text("-3.25");
    run_text("9:8:7xyz");
    run_text("\v\f\015\n42");
    run_text("1: 2: 3");
    run_text("1:2:");
    text_q = '{8'h31, 8'h00};
    send_text();
    text_q = '{8'hff};
    send_text();
    wait_drained();

    // Random strings, draining now and then
    while (chars_sent < RANDOM_CHARS) begin
      build_random_text();
      send_text();
      if (strings_sent % 50 == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d characters in %0d strings: directed corners, random forms,",
             chars_sent, strings_sent);
    $display("broken and noise text; %0d results compared, %0d parsed, %0d rejected.",
             checked, parsed, checked - parsed);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
